[rtl/b64d_pkg.sv]
// Shared types, constants and the alphabet lookup for the base64 decoder.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3d;
	localparam int QUEUE_DEPTH = 2;

	// Position within a four-character group.
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sext_t;

	// One decode job handed from front to back.
	typedef struct packed {
		logic        is_err;
		logic [23:0] word;
		logic [1:0]  nbytes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic sext_t sextet_of(logic [7:0] c);
		sext_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c inside {[8'h41:8'h5a]}) begin
			r.val = 6'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7a]}) begin
			r.val = 6'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			r.val = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2b) begin
			r.val = 6'd62;
		end else if (c == 8'h2f) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

[rtl/b64d_front.sv]
// Front end: classifies characters, assembles groups and issues decode jobs.
module b64d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      char_code,
	input  logic            last_char,
	output logic            push,
	output b64d_pkg::job_t  job
);

	logic [1:0]  pos_q;
	logic [17:0] bits_q;
	logic [1:0]  bcnt_q;
	logic        dropping_q;

	logic [1:0]  pos_d;
	logic [17:0] bits_d;
	logic [1:0]  bcnt_d;
	logic        dropping_d;

	b64d_pkg::sext_t sx;
	logic            is_pad;
	logic            ok;
	logic [5:0]      v;

	always_comb begin
		sx     = b64d_pkg::sextet_of(char_code);
		is_pad = (char_code == b64d_pkg::PAD_CHAR);
		// pad allowed only on the back half of a group
		ok     = sx.ok || (is_pad && pos_q[1]);
		v      = sx.ok ? sx.val : 6'd0;
	end

	always_comb begin
		pos_d       = pos_q;
		bits_d      = bits_q;
		bcnt_d      = bcnt_q;
		dropping_d  = dropping_q;
		push        = 1'b0;
		job.is_err  = 1'b0;
		job.word    = {bits_q, v};
		job.nbytes  = bcnt_q + {1'b0, sx.ok};
		if (accept) begin
			if (dropping_q) begin
				if (last_char) begin
					dropping_d = 1'b0;
					pos_d      = b64d_pkg::POS_FIRST;
					bcnt_d     = 2'd1;
				end
			end else if (!ok || (last_char && pos_q != b64d_pkg::POS_FOURTH)) begin
				push       = 1'b1;
				job.is_err = 1'b1;
				pos_d      = b64d_pkg::POS_FIRST;
				bcnt_d     = 2'd1;
				dropping_d = !last_char;
			end else if (pos_q == b64d_pkg::POS_FOURTH) begin
				push   = 1'b1;
				pos_d  = b64d_pkg::POS_FIRST;
				bcnt_d = 2'd1;
			end else begin
				bits_d = {bits_q[11:0], v};
				pos_d  = pos_q + 2'd1;
				if (pos_q == b64d_pkg::POS_THIRD && sx.ok) begin
					bcnt_d = bcnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= b64d_pkg::POS_FIRST;
			bcnt_q     <= 2'd1;
			dropping_q <= 1'b0;
		end else begin
			pos_q      <= pos_d;
			bcnt_q     <= bcnt_d;
			dropping_q <= dropping_d;
		end
	end

	// old sextets shift out before they reach a word, so no reset needed
	always_ff @(posedge clk) begin
		bits_q <= bits_d;
	end

endmodule

[rtl/b64d_queue.sv]
// Two-entry job queue between the front end and the byte emitter.
module b64d_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::job_t      push_job,
	input  logic                pop,
	output b64d_pkg::job_t      head,
	output b64d_pkg::qstat_t    stat
);

	localparam int AW = $clog2(b64d_pkg::QUEUE_DEPTH);

	b64d_pkg::job_t mem [b64d_pkg::QUEUE_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	always_comb begin
		stat.full  = (cnt_q == (AW+1)'(b64d_pkg::QUEUE_DEPTH));
		stat.empty = (cnt_q == '0);
		head       = mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/b64d_back.sv]
// Back end: walks the head job out one result word per cycle while the output is not stalled.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::job_t      head,
	input  logic                head_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          data_byte,
	output logic                is_error,
	output logic                run_last
);

	logic [1:0] k_q;
	logic       load;
	logic [7:0] sel_byte;
	logic       fin;

	always_comb begin
		case (k_q)
			2'd0:    sel_byte = head.word[23:16];
			2'd1:    sel_byte = head.word[15:8];
			2'd2:    sel_byte = head.word[7:0];
			default: sel_byte = 8'h00;
		endcase
		load = head_valid && (!out_valid || !out_stall);
		fin  = head.is_err || ((k_q + 2'd1) == head.nbytes);
		pop  = load && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				k_q       <= fin ? 2'd0 : k_q + 2'd1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_byte <= head.is_err ? 8'h00 : sel_byte;
			is_error  <= head.is_err;
			run_last  <= fin;
		end
	end

endmodule

[rtl/base64_decoder.sv]
// Top level of the base64 decoder: front end, job queue and byte emitter.
// Takes one base64 character per cycle; a finished group's bytes (one to
// three) or an error word leave one per cycle from a registered output
// while out_stall is low, after passing through the job queue and the
// output register. The input stalls only while the two-entry job queue is
// full, which happens when the output side is stalled or drains slower
// than jobs arrive. With a free-running sink a three-byte group drains one
// byte at a time, so error words that follow right behind such a group can
// fill the queue and stall the input; plain groups alone never stall it.
module base64_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_error,
	output logic       run_last
);

	logic               accept;
	logic               push;
	logic               pop;
	b64d_pkg::job_t     job;
	b64d_pkg::job_t     head;
	b64d_pkg::qstat_t   qstat;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.last_char (last_char),
		.push      (push),
		.job       (job)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!qstat.empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.is_error   (is_error),
		.run_last   (run_last)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> data_byte == 8'h00)
		else $error("error word carries nonzero data");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> run_last)
		else $error("error word not marked last");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(push))
		else $error("queue filled without a push");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

[tb/tb_base64_decoder.sv]
// Self-checking testbench for the base64 decoder: directed table, random streams, stall phases.
module tb_base64_decoder;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       err;
		logic       fin;
	} b64_result_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       lst;
	} b64_char_t;

	// known = 1: the row carries its own expected words, otherwise the decoder model decides
	typedef struct packed {
		logic [7:0]  ch;
		logic        lst;
		logic        known;
		logic [1:0]  cnt;
		logic [23:0] bytes;
		logic        err;
	} dir_row_t;

	localparam dir_row_t DIRECTED [26] = '{
		'{"T", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"W", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"F", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"u", 1'b0, 1'b1, 2'd3, 24'h4d616e, 1'b0},
		'{"/", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"/", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"/", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"/", 1'b1, 1'b1, 2'd3, 24'hffffff, 1'b0},
		'{"A", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"A", 1'b1, 1'b1, 2'd3, 24'h000000, 1'b0},
		'{b64d_pkg::PAD_CHAR, 1'b0, 1'b1, 2'd1, 24'h000000, 1'b1},
		'{8'h80, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"Q", 1'b1, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{8'hff, 1'b1, 1'b1, 2'd1, 24'h000000, 1'b1},
		'{"Q", 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
		'{"Q", 1'b1, 1'b1, 2'd1, 24'h000000, 1'b1},
		'{"Q", 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"Q", 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{b64d_pkg::PAD_CHAR, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{b64d_pkg::PAD_CHAR, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"Q", 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"U", 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{b64d_pkg::PAD_CHAR, 1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
		'{"D", 1'b1, 1'b0, 2'd0, 24'h000000, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       last_char = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] data_byte;
	logic       is_error;
	logic       run_last;

	// decoder model state
	logic [1:0]  grp_pos = b64d_pkg::POS_FIRST;
	logic [17:0] sext_acc = '0;
	logic [1:0]  yield_cnt = 2'd1;
	logic        skipping = 1'b0;

	b64_result_t pending_words [$];
	b64_char_t   stim_q [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int mismatches = 0;
	int chars_sent = 0;
	int bytes_checked = 0;
	int errors_checked = 0;

	base64_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.is_error  (is_error),
		.run_last  (run_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected", cycle_cnt,
				pending_words.size());
			$display("Verification failed");
			$finish;
		end
	end

	// {valid, sextet}
	function automatic logic [6:0] alpha_index(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5a) return {1'b1, 6'(c - 8'h41)};
		if (c >= 8'h61 && c <= 8'h7a) return {1'b1, 6'(c - 8'h61 + 8'd26)};
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30 + 8'd52)};
		if (c == 8'h2b) return {1'b1, 6'd62};
		if (c == 8'h2f) return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		if (v < 6'd26) return 8'h41 + 8'(v);
		if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
		if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
		return (v == 6'd62) ? 8'h2b : 8'h2f;
	endfunction

	function automatic void restart_group();
		grp_pos = b64d_pkg::POS_FIRST;
		sext_acc = '0;
		yield_cnt = 2'd1;
	endfunction

	// Advances the decoder model by one character; returns how many words it yields.
	function automatic int decode_char(input logic [7:0] c, input logic lst,
		output b64_result_t res [3]);
		logic       ok;
		logic [5:0] sx;
		logic       fail;
		logic [23:0] word;
		int         n;
		n = 0;
		fail = 1'b0;
		if (skipping) begin
			if (lst) begin
				restart_group();
				skipping = 1'b0;
			end
			return 0;
		end
		if (grp_pos == b64d_pkg::POS_FIRST || grp_pos == b64d_pkg::POS_SECOND) begin
			{ok, sx} = alpha_index(c);
			if (!ok) begin
				fail = 1'b1;
			end else begin
				sext_acc = {sext_acc[11:0], sx};
				grp_pos = grp_pos + 2'd1;
				fail = lst;
			end
		end else begin
			if (c == b64d_pkg::PAD_CHAR) begin
				ok = 1'b1;
				sx = 6'd0;
			end else begin
				{ok, sx} = alpha_index(c);
				if (ok) yield_cnt = yield_cnt + 2'd1;
			end
			if (!ok) begin
				fail = 1'b1;
			end else if (grp_pos == b64d_pkg::POS_THIRD) begin
				sext_acc = {sext_acc[11:0], sx};
				grp_pos = b64d_pkg::POS_FOURTH;
				fail = lst;
			end else begin
				word = {sext_acc, sx};
				n = int'(yield_cnt);
				for (int k = 0; k < n; k++)
					res[k] = '{word[23 - 8 * k -: 8], 1'b0, (k == n - 1)};
				restart_group();
			end
		end
		if (fail) begin
			res[0] = '{8'h00, 1'b1, 1'b1};
			restart_group();
			skipping = !lst;
			n = 1;
		end
		return n;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		b64_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (is_error) errors_checked++;
			else bytes_checked++;
			if (pending_words.size() == 0) begin
				flag_mismatch($sformatf("unexpected word data=%02h err=%b last=%b",
					data_byte, is_error, run_last));
			end else begin
				want = pending_words.pop_front();
				if (data_byte !== want.data)
					flag_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
				if (is_error !== want.err)
					flag_mismatch($sformatf("is_error %b, want %b", is_error, want.err));
				if (run_last !== want.fin)
					flag_mismatch($sformatf("run_last %b, want %b", run_last, want.fin));
			end
		end
	end

	// Output side: random stall, or a forced hold-off while hold_left runs down.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic lst);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		chars_sent++;
	endtask

	task automatic feed_char(input logic [7:0] c, input logic lst);
		b64_result_t r [3];
		int n;
		send_char(c, lst);
		n = decode_char(c, lst, r);
		for (int k = 0; k < n; k++) pending_words.push_back(r[k]);
	endtask

	// Mostly clean streams; some with mid-stream padding, truncated or with a bad character.
	task automatic queue_stream();
		int groups;
		int m;
		int kind;
		int pos;
		logic [7:0] g [4];
		b64_char_t s [$];
		kind = $urandom_range(99);
		groups = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
		for (int i = 0; i < groups; i++) begin
			m = (i == groups - 1 || kind >= 70) ? $urandom_range(1, 3) : 3;
			for (int j = 0; j < 4; j++) g[j] = alpha_char(6'($urandom_range(63)));
			if (m < 3) g[3] = b64d_pkg::PAD_CHAR;
			if (m < 2 || (kind >= 70 && $urandom_range(3) == 0)) g[2] = b64d_pkg::PAD_CHAR;
			for (int j = 0; j < 4; j++) s.push_back('{g[j], 1'b0});
		end
		if (kind >= 80 && kind < 90) begin
			repeat ($urandom_range(1, 3)) void'(s.pop_back());
		end else if (kind >= 90) begin
			pos = $urandom_range(s.size() - 1);
			s[pos].ch = 8'($urandom_range(255));
		end
		s[s.size() - 1].lst = 1'b1;
		foreach (s[k]) stim_q.push_back(s[k]);
	endtask

	task automatic run_random(input int n);
		b64_char_t it;
		int done;
		done = 0;
		while (done < n) begin
			if ($urandom_range(99) < 85) begin
				queue_stream();
			end else begin
				// raw bytes, closed with an end of stream so the next stream starts clean
				repeat ($urandom_range(1, 6))
					stim_q.push_back('{8'($urandom_range(255)), ($urandom_range(9) == 0)});
				stim_q[stim_q.size() - 1].lst = 1'b1;
			end
			while (stim_q.size() != 0) begin
				it = stim_q.pop_front();
				feed_char(it.ch, it.lst);
				done++;
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	initial begin
		b64_result_t r [3];
		int n;
		dir_row_t row;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 7;
		stall_pct = 46;
		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			send_char(row.ch, row.lst);
			n = decode_char(row.ch, row.lst, r);
			if (row.known) begin
				if (row.err) begin
					pending_words.push_back('{8'h00, 1'b1, 1'b1});
				end else begin
					for (int k = 0; k < int'(row.cnt); k++)
						pending_words.push_back('{row.bytes[23 - 8 * k -: 8], 1'b0,
							(k == int'(row.cnt) - 1)});
				end
			end else begin
				for (int k = 0; k < n; k++) pending_words.push_back(r[k]);
			end
		end
		wait_idle();

		run_random(120);
		// freeze the output side while characters keep coming, so the job queue backs up
		hold_left = 80;
		run_random(30);
		wait_idle();

		gap_pct = 46;
		stall_pct = 7;
		run_random(120);
		wait_idle();

		gap_pct = 0;
		stall_pct = 0;
		run_random(120);
		wait_idle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_words.size() != 0)
			flag_mismatch($sformatf("%0d words never arrived", pending_words.size()));
		$display("Sent %0d characters; checked %0d data bytes and %0d error words",
			chars_sent, bytes_checked, errors_checked);
		$display("Covered clean and padded groups, truncation, bad characters, drops, backpressure");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_decoder.sv
tb/tb_base64_decoder.sv
